// ===== design/sao_pkg.sv =====
// ----------------------------------------------------------------------------
// sao_pkg - shared types and constants of the SAO pixel offset filter
// Field widths, register indexes, mode codes and the configuration bundle
// that the top level hands to the per-pixel datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sao_pkg;

    localparam int PIX_W       = 10;  // pixel port width
    localparam int MODE_W      = 3;   // sao_mode register width
    localparam int DEPTH_W     = 4;   // sample_depth register width
    localparam int OFS_W       = 8;   // one signed offset entry
    localparam int NUM_OFS     = 5;   // entries in offset_table
    localparam int OFS_TABLE_W = OFS_W * NUM_OFS;
    localparam int BAND_ID_W   = 5;   // one band id
    localparam int NUM_BANDS   = 4;   // entries in band_table
    localparam int BAND_TABLE_W = BAND_ID_W * NUM_BANDS;
    localparam int SIDE_W      = 4;   // side_available width
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = OFS_TABLE_W;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAO_MODE       = 3'd0,
        REG_SAMPLE_DEPTH   = 3'd1,
        REG_OFFSET_TABLE   = 3'd2,
        REG_BAND_TABLE     = 3'd3,
        REG_SIDE_AVAILABLE = 3'd4
    } sao_reg_idx_t;

    // Filter modes
    typedef enum logic [MODE_W-1:0] {
        MODE_EDGE_HOR  = 3'd0,
        MODE_EDGE_VER  = 3'd1,
        MODE_EDGE_135  = 3'd2,
        MODE_EDGE_45   = 3'd3,
        MODE_BAND      = 3'd4
    } sao_mode_t;

    // Side availability bit positions
    localparam int SIDE_LEFT  = 0;
    localparam int SIDE_RIGHT = 1;
    localparam int SIDE_UP    = 2;
    localparam int SIDE_DOWN  = 3;

    // Register values after reset
    localparam logic [MODE_W-1:0]       RST_SAO_MODE       = 3'd0;
    localparam logic [DEPTH_W-1:0]      RST_SAMPLE_DEPTH   = 4'd8;
    localparam logic [OFS_TABLE_W-1:0]  RST_OFFSET_TABLE   = '0;
    localparam logic [BAND_TABLE_W-1:0] RST_BAND_TABLE     = '0;
    localparam logic [SIDE_W-1:0]       RST_SIDE_AVAILABLE = 4'hF;

    // Configuration bundle
    typedef struct packed {
        logic [MODE_W-1:0]       sao_mode;
        logic [DEPTH_W-1:0]      sample_depth;
        logic [OFS_TABLE_W-1:0]  offset_table;
        logic [BAND_TABLE_W-1:0] band_table;
        logic [SIDE_W-1:0]       side_available;
    } sao_cfg_t;

    // One registered input pixel with its position flags
    typedef struct packed {
        logic [PIX_W-1:0] center_pixel;
        logic [PIX_W-1:0] first_neighbor;
        logic [PIX_W-1:0] second_neighbor;
        logic             at_left_col;
        logic             at_right_col;
        logic             at_top_row;
        logic             at_bottom_row;
    } sao_pix_t;

endpackage

`default_nettype wire

// ===== design/sao_pixel_offset_filter_core.sv =====
// ----------------------------------------------------------------------------
// sao_pixel_offset_filter_core - sample adaptive offset filter, one pixel/clk
// Edge and band offset of a pixel stream with clipping to the sample depth.
// ----------------------------------------------------------------------------
// Usage: pulse start with a pixel, its two neighbours along the mode's
// direction and the four block-position flags. busy never rises, so a new
// word is taken on every clock. Each word returns exactly one filtered pixel
// on filtered_pixel with done high for a single cycle. done rises at the
// edge after the one that took the word: the input register loads at the
// edge that takes the word and the result register at the next. The result is
// accepted at the edge that ends the done cycle. Results come out in order
// and the receiver cannot stall them, so capture on done. Sustained
// rate is one pixel per clock; the classify/offset/clip path between the two
// registers sets the clock. Configuration registers are written through
// cfg_valid/cfg_ready (always ready) at cfg_index; write them only while no
// pixel is in flight.
`default_nettype none

module sao_pixel_offset_filter_core #(
    parameter int MAX_SAMPLE_BITS = 10,
    parameter int BAND_SHIFT_BITS = 5
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sao_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sao_pkg::CFG_DATA_W-1:0]  cfg_data,
    // pixel command
    input  logic                            start,
    output logic                            busy,
    input  logic [sao_pkg::PIX_W-1:0]       center_pixel,
    input  logic [sao_pkg::PIX_W-1:0]       first_neighbor,
    input  logic [sao_pkg::PIX_W-1:0]       second_neighbor,
    input  logic                            at_left_col,
    input  logic                            at_right_col,
    input  logic                            at_top_row,
    input  logic                            at_bottom_row,
    // result
    output logic                            done,
    output logic [sao_pkg::PIX_W-1:0]       filtered_pixel
);
    import sao_pkg::*;

    sao_cfg_t         cfg_reg;
    sao_cfg_t         cfg_next;
    logic             in_valid_reg;
    sao_pix_t         pix_reg;
    logic             done_reg;
    logic [PIX_W-1:0] result_reg;
    logic [PIX_W-1:0] result_next;
    logic             accept;

    // The pipeline never backs up, so both channels are always open
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Register write decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (sao_reg_idx_t'(cfg_index))
                REG_SAO_MODE:       cfg_next.sao_mode       = cfg_data[MODE_W-1:0];
                REG_SAMPLE_DEPTH:   cfg_next.sample_depth   = cfg_data[DEPTH_W-1:0];
                REG_OFFSET_TABLE:   cfg_next.offset_table   = cfg_data[OFS_TABLE_W-1:0];
                REG_BAND_TABLE:     cfg_next.band_table     = cfg_data[BAND_TABLE_W-1:0];
                REG_SIDE_AVAILABLE: cfg_next.side_available = cfg_data[SIDE_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sao_mode       <= RST_SAO_MODE;
            cfg_reg.sample_depth   <= RST_SAMPLE_DEPTH;
            cfg_reg.offset_table   <= RST_OFFSET_TABLE;
            cfg_reg.band_table     <= RST_BAND_TABLE;
            cfg_reg.side_available <= RST_SIDE_AVAILABLE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Stage 1: capture the incoming word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg.center_pixel    <= center_pixel;
            pix_reg.first_neighbor  <= first_neighbor;
            pix_reg.second_neighbor <= second_neighbor;
            pix_reg.at_left_col     <= at_left_col;
            pix_reg.at_right_col    <= at_right_col;
            pix_reg.at_top_row      <= at_top_row;
            pix_reg.at_bottom_row   <= at_bottom_row;
        end
    end

    // Classify, offset and clip
    sao_pix_calc #(
        .MAX_SAMPLE_BITS (MAX_SAMPLE_BITS),
        .BAND_SHIFT_BITS (BAND_SHIFT_BITS)
    ) u_calc (
        .cfg            (cfg_reg),
        .pix            (pix_reg),
        .filtered_pixel (result_next)
    );

    // Stage 2: hold the result for its single strobe cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
            result_reg <= result_next;
    end

    assign done           = done_reg;
    assign filtered_pixel = result_reg;

endmodule

`default_nettype wire

// ===== design/sao_pix_calc.sv =====
// ----------------------------------------------------------------------------
// sao_pix_calc - per-pixel offset datapath
// Classifies one pixel (edge or band), picks its offset, adds and clips.
// Purely combinational; sits between the input and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sao_pix_calc #(
    parameter int MAX_SAMPLE_BITS = 10,
    parameter int BAND_SHIFT_BITS = 5
) (
    input  sao_pkg::sao_cfg_t                cfg,
    input  sao_pkg::sao_pix_t                pix,
    output logic [sao_pkg::PIX_W-1:0]        filtered_pixel
);
    import sao_pkg::*;

    localparam int SUM_W = ((MAX_SAMPLE_BITS > PIX_W) ? MAX_SAMPLE_BITS : PIX_W) + 2;
    localparam logic [DEPTH_W-1:0] MAX_D  = DEPTH_W'(MAX_SAMPLE_BITS);
    localparam logic [DEPTH_W-1:0] BAND_D = DEPTH_W'(BAND_SHIFT_BITS);
    localparam int OFS_IDX_W = $clog2(NUM_OFS);

    logic [DEPTH_W-1:0]         depth_sat;
    logic [MAX_SAMPLE_BITS-1:0] max_val;
    logic                       skip_h;
    logic                       skip_v;
    logic                       gt1, lt1, gt2, lt2;
    logic [OFS_IDX_W-1:0]       edge_idx;
    logic [PIX_W-1:0]           band_val;
    logic                       band_hit;
    logic [OFS_IDX_W-1:0]       band_idx;
    logic                       apply;
    logic [OFS_IDX_W-1:0]       ofs_idx;
    logic signed [OFS_W-1:0]    ofs_val;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SUM_W-1:0]    max_ext;
    logic [SUM_W-1:0]           clipped;

    // Saturate the depth so the band shift never goes negative
    always_comb
    begin
        if (cfg.sample_depth > MAX_D)
            depth_sat = MAX_D;
        else if (cfg.sample_depth < BAND_D)
            depth_sat = BAND_D;
        else
            depth_sat = cfg.sample_depth;
    end

    assign max_val = {MAX_SAMPLE_BITS{1'b1}} >> (MAX_D - depth_sat);

    assign skip_h = (pix.at_left_col  && !cfg.side_available[SIDE_LEFT]) ||
                    (pix.at_right_col && !cfg.side_available[SIDE_RIGHT]);
    assign skip_v = (pix.at_top_row    && !cfg.side_available[SIDE_UP]) ||
                    (pix.at_bottom_row && !cfg.side_available[SIDE_DOWN]);

    // Edge class + 2 lands in 0..4
    assign gt1 = pix.center_pixel > pix.first_neighbor;
    assign lt1 = pix.center_pixel < pix.first_neighbor;
    assign gt2 = pix.center_pixel > pix.second_neighbor;
    assign lt2 = pix.center_pixel < pix.second_neighbor;
    assign edge_idx = OFS_IDX_W'(2) + OFS_IDX_W'(gt1) + OFS_IDX_W'(gt2)
                      - OFS_IDX_W'(lt1) - OFS_IDX_W'(lt2);

    // Band lookup: first matching id wins
    assign band_val = pix.center_pixel >> (depth_sat - BAND_D);

    always_comb
    begin
        band_hit = 1'b0;
        band_idx = '0;
        for (int i = NUM_BANDS - 1; i >= 0; i--)
        begin
            if (band_val == PIX_W'(cfg.band_table[i*BAND_ID_W +: BAND_ID_W]))
            begin
                band_hit = 1'b1;
                band_idx = OFS_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        case (cfg.sao_mode)
            MODE_EDGE_HOR:
            begin
                apply   = !skip_h;
                ofs_idx = edge_idx;
            end
            MODE_EDGE_VER:
            begin
                apply   = !skip_v;
                ofs_idx = edge_idx;
            end
            MODE_EDGE_135, MODE_EDGE_45:
            begin
                apply   = !(skip_h || skip_v);
                ofs_idx = edge_idx;
            end
            MODE_BAND:
            begin
                apply   = band_hit;
                ofs_idx = band_idx;
            end
            default:
            begin
                apply   = 1'b0;
                ofs_idx = '0;
            end
        endcase
    end

    assign ofs_val = $signed(cfg.offset_table[ofs_idx*OFS_W +: OFS_W]);
    assign sum     = $signed({{(SUM_W-PIX_W){1'b0}}, pix.center_pixel})
                     + SUM_W'(ofs_val);
    assign max_ext = $signed({{(SUM_W-MAX_SAMPLE_BITS){1'b0}}, max_val});

    always_comb
    begin
        if (sum < 0)
            clipped = '0;
        else if (sum > max_ext)
            clipped = max_ext;
        else
            clipped = sum;
    end

    assign filtered_pixel = apply ? clipped[PIX_W-1:0] : pix.center_pixel;

endmodule

`default_nettype wire
